>>> hw/rtl/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the tilt posture monitor
// Holds register indexes, the CORDIC arctangent table and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package tpm_pkg;

  localparam int MAX_STEPS = 24;
  localparam int ANG_W = 26;  // degrees Q16 accumulator, covers +-360
  localparam logic signed [15:0] ANGLE_LIMIT_Q8 = 16'sd23040;
  localparam logic signed [ANG_W-1:0] DEG45_Q16 = 26'sd2949120;

  typedef enum logic [2:0] {
    REG_FILTER_GAIN    = 3'd0,
    REG_MOTION_LIMIT   = 3'd1,
    REG_ORIGIN_Y       = 3'd2,
    REG_ORIGIN_Z       = 3'd3,
    REG_STRAIGHT_LIMIT = 3'd4,
    REG_GOOD_LIMIT     = 3'd5,
    REG_SETTLE_MS      = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } dir_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;
      5'd2: r = 26'sd919879;   5'd3: r = 26'sd466945;
      5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;
      5'd8: r = 26'sd14668;    5'd9: r = 26'sd7334;
      5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;     5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;     5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;       5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Entry handed from the filter front to the angle back.
  typedef struct packed {
    logic signed [31:0] fz;   // filtered Z, Q16 (fits 32 bits for 16-bit samples)
    logic        [31:0] fya;  // |filtered Y|, Q16
    logic               inv;
    logic               moving;
    logic        [31:0] now;
  } job_t;

endpackage
`default_nettype wire

>>> hw/rtl/tilt_posture_monitor.sv
// ----------------------------------------------------------------------------
// tilt_posture_monitor: accelerometer posture tilt monitor
// Filters samples, measures tilt by CORDIC and raises a debounced alarm.
// ----------------------------------------------------------------------------
// Each request carries one three-axis sample and a millisecond time stamp and
// yields exactly one result. A front stage runs the three low-pass filters,
// one axis per cycle, plus the motion check, and hands a job to a one-entry
// queue. A back stage runs two iterative CORDIC passes (current angle, then
// origin angle) on one shared add/shift unit, and then the zone and alarm
// logic. The sustained rate is set by that unit, while the front can
// already filter the next sample. Registers are written through a
// plain write port and should only change while the block is idle.
`default_nettype none
module tilt_posture_monitor #(
  parameter int SAMPLE_BITS  = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_z,
  input  wire logic        [31:0]            now_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [15:0]                 tilt_angle,
  output logic        [1:0]                  direction,
  output logic                               outside_good_zone,
  output logic                               alarm,
  output logic                               moving,
  output logic                               inverted
);
  import tpm_pkg::*;

  logic [15:0] filter_gain, settle_ms;
  logic [13:0] motion_limit;
  logic [10:0] origin_y;
  logic signed [11:0] origin_z;
  logic [14:0] straight_limit, good_limit;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain <= 16'd6554;
      motion_limit <= 14'd204;
      origin_y <= 11'd688;
      origin_z <= 12'sd688;
      straight_limit <= 15'd5120;
      good_limit <= 15'd6400;
      settle_ms <= 16'd100;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_FILTER_GAIN:    filter_gain <= cfg_data;
        REG_MOTION_LIMIT:   motion_limit <= cfg_data[13:0];
        REG_ORIGIN_Y:       origin_y <= cfg_data[10:0];
        REG_ORIGIN_Z:       origin_z <= cfg_data[11:0];
        REG_STRAIGHT_LIMIT: straight_limit <= cfg_data[14:0];
        REG_GOOD_LIMIT:     good_limit <= cfg_data[14:0];
        REG_SETTLE_MS:      settle_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // The job register inside the front is the queue between the two parts.
  logic job_valid, job_ready;
  job_t job;

  tpm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .sx(accel_x), .sy(accel_y), .sz(accel_z), .now(now_ms),
    .filter_gain, .motion_limit,
    .job_valid, .job_ready, .job
  );

  tpm_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .origin_y, .origin_z, .straight_limit, .good_limit, .settle_ms,
    .out_valid, .out_ready, .tilt_angle, .direction, .outside_good_zone,
    .alarm, .moving, .inverted
  );

endmodule
`default_nettype wire

>>> hw/rtl/tpm_front.sv
// ----------------------------------------------------------------------------
// tpm_front: sample intake
// Runs the three low-pass filters one axis per cycle and the motion check.
// ----------------------------------------------------------------------------
`default_nettype none
module tpm_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sx,
  input  wire logic signed [SAMPLE_BITS-1:0] sy,
  input  wire logic signed [SAMPLE_BITS-1:0] sz,
  input  wire logic        [31:0]            now,
  input  wire logic        [15:0]            filter_gain,
  input  wire logic        [13:0]            motion_limit,
  output logic                               job_valid,
  input  wire logic                          job_ready,
  output tpm_pkg::job_t                      job
);
  import tpm_pkg::*;

  localparam int FW = SAMPLE_BITS + 16;

  typedef enum logic [2:0] {F_IDLE, F_AX, F_AY, F_AZ, F_PUSH} fstate_t;
  fstate_t state;

  logic signed [FW-1:0] filt [3];
  logic signed [SAMPLE_BITS-1:0] prev [3];
  logic signed [SAMPLE_BITS-1:0] samp [3];
  logic [31:0] now_r;
  logic seed, moving_r;
  logic [1:0] ax;

  // One filter update for the axis selected by ax.
  logic signed [FW:0] diff;
  logic signed [FW+17:0] prod;
  logic signed [FW-1:0] fnew;
  always_comb begin
    diff = {samp[ax][SAMPLE_BITS-1], samp[ax], 16'd0} - {filt[ax][FW-1], filt[ax]};
    prod = diff * $signed({1'b0, filter_gain});
    fnew = seed ? FW'({samp[ax], 16'd0}) : FW'(filt[ax] + FW'(prod >>> 16));
  end

  logic [SAMPLE_BITS:0] dx, dy, dz;
  logic [SAMPLE_BITS+2:0] motion;
  always_comb begin
    logic signed [SAMPLE_BITS:0] a, b, c;
    a = {sx[SAMPLE_BITS-1], sx} - {prev[0][SAMPLE_BITS-1], prev[0]};
    b = {sy[SAMPLE_BITS-1], sy} - {prev[1][SAMPLE_BITS-1], prev[1]};
    c = {sz[SAMPLE_BITS-1], sz} - {prev[2][SAMPLE_BITS-1], prev[2]};
    dx = a[SAMPLE_BITS] ? -a : a;
    dy = b[SAMPLE_BITS] ? -b : b;
    dz = c[SAMPLE_BITS] ? -c : c;
    motion = (SAMPLE_BITS+3)'(dx) + (SAMPLE_BITS+3)'(dy) + (SAMPLE_BITS+3)'(dz);
  end

  assign in_ready = (state == F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      job_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        filt[i] <= '0;
        prev[i] <= '0;
      end
    end else begin
      unique case (state)
        F_IDLE: if (in_valid) begin
          samp[0] <= sx; samp[1] <= sy; samp[2] <= sz;
          prev[0] <= sx; prev[1] <= sy; prev[2] <= sz;
          now_r <= now;
          moving_r <= (32'(motion) > 32'(motion_limit));
          seed <= (filt[0] == '0) && (filt[1] == '0) && (filt[2] == '0);
          ax <= 2'd0;
          state <= F_AX;
        end
        F_AX: begin filt[0] <= fnew; ax <= 2'd1; state <= F_AY; end
        F_AY: begin filt[1] <= fnew; ax <= 2'd2; state <= F_AZ; end
        F_AZ: begin filt[2] <= fnew; state <= F_PUSH; end
        F_PUSH: if (!job_valid || job_ready) begin
          job_valid <= 1'b1;
          job.fz <= 32'(filt[2]);
          job.fya <= filt[1][FW-1] ? (32'd0 - 32'(filt[1])) : 32'(filt[1]);
          job.inv <= filt[1][FW-1] || (filt[1] == '0);
          job.moving <= moving_r;
          job.now <= now_r;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
      if (job_valid && job_ready && !(state == F_PUSH)) job_valid <= 1'b0;
    end
  end

  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    (state == F_PUSH && (!job_valid || job_ready)) |=> job_valid && state == F_IDLE)
    else $error("front push lost");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == F_AX)
    else $error("front did not start");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid)
    else $error("job dropped");

endmodule
`default_nettype wire

>>> hw/rtl/tpm_back.sv
// ----------------------------------------------------------------------------
// tpm_back: angle and posture logic
// Iterative CORDIC for current and origin angle, then zone and alarm logic.
// ----------------------------------------------------------------------------
`default_nettype none
module tpm_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  tpm_pkg::job_t           job,
  input  wire logic        [10:0] origin_y,
  input  wire logic signed [11:0] origin_z,
  input  wire logic        [14:0] straight_limit,
  input  wire logic        [14:0] good_limit,
  input  wire logic        [15:0] settle_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      tilt_angle,
  output logic        [1:0]       direction,
  output logic                    outside_good_zone,
  output logic                    alarm,
  output logic                    moving,
  output logic                    inverted
);
  import tpm_pkg::*;

  localparam int VW = 38;  // vector width with CORDIC growth headroom
  localparam int STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

  typedef enum logic [2:0] {B_IDLE, B_CUR, B_ORG, B_FIN, B_OUT} bstate_t;
  bstate_t state;

  logic signed [VW-1:0] x, y;
  logic signed [ANG_W-1:0] ang, cur;
  logic [4:0] step;
  job_t jb;
  logic alarm_flag, gs_valid;
  logic [31:0] gs_time;

  logic signed [VW-1:0] xs, ys;
  logic signed [ANG_W-1:0] at;
  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    at = atan_entry(step);
  end

  // Starting vector of the origin angle pass.
  logic signed [VW-1:0] org_x0, org_y0;
  assign org_x0 = VW'({origin_y, 16'd0});
  assign org_y0 = VW'($signed({origin_z, 16'd0}));

  logic last;
  assign last = (step == 5'(STEPS - 1));

  logic signed [ANG_W-1:0] rel;
  logic signed [ANG_W-1:0] q8;
  logic signed [15:0] angle;
  always_comb begin
    rel = cur - ang;
    q8 = (rel + ANG_W'(128)) >>> 8;
    if (q8 > ANG_W'(ANGLE_LIMIT_Q8)) angle = ANGLE_LIMIT_Q8;
    else if (q8 < -ANG_W'(ANGLE_LIMIT_Q8)) angle = -ANGLE_LIMIT_Q8;
    else angle = 16'(q8);
  end

  logic signed [16:0] a17, sl, gl;
  assign a17 = {angle[15], angle};
  assign sl = {2'b00, straight_limit};
  assign gl = {2'b00, good_limit};

  assign job_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      alarm_flag <= 1'b0;
      gs_valid <= 1'b0;
      gs_time <= '0;
    end else begin
      unique case (state)
        B_IDLE: if (job_valid) begin
          jb <= job;
          x <= VW'(job.fya);
          y <= VW'($signed(job.fz));
          ang <= '0;
          step <= '0;
          state <= B_CUR;
        end
        B_CUR: begin
          if (x == '0 && y == '0 && step == '0) begin
            // Zero vector: the current angle is zero.
            cur <= '0;
            x <= org_x0;
            y <= org_y0;
            ang <= '0;
            step <= '0;
            state <= B_ORG;
          end else if (last) begin
            cur <= (y >= 0) ? ang + at : ang - at;
            x <= org_x0;
            y <= org_y0;
            ang <= '0;
            step <= '0;
            state <= B_ORG;
          end else begin
            if (y >= 0) begin
              x <= x + ys; y <= y - xs; ang <= ang + at;
            end else begin
              x <= x - ys; y <= y + xs; ang <= ang - at;
            end
            step <= step + 5'd1;
          end
        end
        B_ORG: begin
          if (origin_y == '0 && origin_z == '0) begin
            ang <= DEG45_Q16;
            state <= B_FIN;
          end else begin
            if (y >= 0) begin
              x <= x + ys; y <= y - xs; ang <= ang + at;
            end else begin
              x <= x - ys; y <= y + xs; ang <= ang - at;
            end
            if (last) state <= B_FIN;
            else step <= step + 5'd1;
          end
        end
        B_FIN: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          tilt_angle <= angle;
          direction <= (a17 > sl) ? DIR_FORWARD :
                       (a17 < -sl) ? DIR_BACKWARD : DIR_STRAIGHT;
          outside_good_zone <= (a17 > gl) || (a17 < -gl);
          moving <= jb.moving;
          inverted <= jb.inv;
          if (a17 > gl) begin
            alarm_flag <= 1'b1;
            alarm <= 1'b1;
            gs_valid <= 1'b0;
          end else begin
            logic [31:0] st;
            st = gs_valid ? gs_time : jb.now;
            gs_valid <= 1'b1;
            gs_time <= st;
            if ((jb.now - st) > {16'd0, settle_ms}) begin
              alarm_flag <= 1'b0;
              alarm <= 1'b0;
            end else alarm <= alarm_flag;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
      if (out_valid && out_ready && !(state == B_FIN)) out_valid <= 1'b0;
    end
  end

  a_alarm_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside_good_zone && tilt_angle > 0 |-> alarm)
    else $error("alarm missing in bad zone");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tilt_angle))
    else $error("result changed while stalled");
  a_step: assert property (@(posedge clk) disable iff (rst)
    state == B_ORG && !last && !(origin_y == '0 && origin_z == '0) |=> state == B_ORG)
    else $error("cordic left early");

endmodule
`default_nettype wire
